// ===== design/nrmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types and constants for the RMC sentence field extractor.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] KIND_LAT    = 3'd0;
  localparam logic [2:0] KIND_LON    = 3'd1;
  localparam logic [2:0] KIND_TIME   = 3'd2;
  localparam logic [2:0] KIND_NOGPS  = 3'd3;
  localparam logic [2:0] KIND_NOTIME = 3'd4;

  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd3;
  localparam logic [3:0] FLD_LATH = 4'd4;
  localparam logic [3:0] FLD_LONH = 4'd6;
  localparam logic [3:0] FLD_DATE = 4'd9;

  localparam logic [3:0] LAT_LEN   = 4'd11;
  localparam logic [3:0] LON_LEN   = 4'd12;
  localparam logic [3:0] STAMP_LEN = 4'd6;
  localparam logic [3:0] BURST_LAST = 4'd11;
  localparam logic [3:0] CNT_MAX   = 4'd15;

  // One queued job: a single result, or a twelve-character time/date burst
  typedef struct packed {
    logic             burst;
    logic [2:0]       kind;
    logic [11:0][7:0] chars;
  } job_t;

endpackage

// ===== design/nrmc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_front
// Byte parser: tracks sentence, field and character position, stores time
// and date characters and posts result jobs to the queue.
// ----------------------------------------------------------------------------
module nrmc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  input  logic               q_full,
  input  logic [7:0]         no_lock_digit,
  output logic               push,
  output nrmc_pkg::job_t     push_job
);
  import nrmc_pkg::*;

  logic       in_sent_r, in_sent_nxt;
  logic [3:0] fld_r, fld_nxt;
  logic [3:0] cif_r, cif_nxt;
  logic       lat_r, lat_nxt;
  logic [5:0][7:0] time_r;
  logic [5:0][7:0] date_r;

  logic       accept;
  logic       start;
  logic       comma;
  logic       lat_eff;
  logic       in_group;
  logic       latg;
  logic [3:0] fld_inc;
  logic [3:0] cif_inc;
  logic       time_wr;
  logic       date_wr;

  assign accept  = in_valid && !q_full;
  assign start   = (in_rx_byte == CH_START);
  assign comma   = (in_rx_byte == CH_COMMA);
  assign fld_inc = (fld_r == CNT_MAX) ? CNT_MAX : fld_r + 4'd1;
  assign cif_inc = (cif_r == CNT_MAX) ? CNT_MAX : cif_r + 4'd1;
  assign lat_eff = (fld_r == FLD_LAT && cif_r == 4'd0) ? !comma : lat_r;
  assign in_group = (fld_r >= FLD_LAT) && (fld_r <= FLD_LONH);
  assign latg    = (fld_r <= FLD_LATH);

  always_comb begin
    in_sent_nxt = in_sent_r;
    fld_nxt     = fld_r;
    cif_nxt     = cif_r;
    lat_nxt     = lat_r;
    push        = 1'b0;
    push_job    = '0;
    time_wr     = 1'b0;
    date_wr     = 1'b0;
    if (accept) begin
      if (start) begin
        in_sent_nxt = 1'b1;
        fld_nxt     = '0;
        cif_nxt     = '0;
        lat_nxt     = 1'b0;
      end else if (in_sent_r) begin
        lat_nxt = lat_eff;
        if (fld_r == FLD_TIME && comma && cif_r == 4'd0) begin
          push          = 1'b1;
          push_job.kind = KIND_NOGPS;
          in_sent_nxt   = 1'b0;
        end else if (in_group) begin
          if (lat_eff && cif_r < (latg ? LAT_LEN : LON_LEN)) begin
            push              = 1'b1;
            push_job.kind     = latg ? KIND_LAT : KIND_LON;
            push_job.chars[0] = in_rx_byte;
          end
          if (comma && (fld_r == FLD_LATH || fld_r == FLD_LONH)) begin
            cif_nxt = '0;
          end else begin
            cif_nxt = cif_inc;
          end
          if (comma) begin
            fld_nxt = fld_inc;
          end
        end else if (comma) begin
          fld_nxt = fld_inc;
          cif_nxt = '0;
        end else begin
          time_wr = (fld_r == FLD_TIME) && (cif_r < STAMP_LEN);
          date_wr = (fld_r == FLD_DATE) && (cif_r < STAMP_LEN);
          if (date_wr && cif_r == STAMP_LEN - 4'd1) begin
            push        = 1'b1;
            in_sent_nxt = 1'b0;
            if (date_r[4] == no_lock_digit) begin
              push_job.kind = KIND_NOTIME;
            end else begin
              push_job.kind  = KIND_TIME;
              push_job.burst = 1'b1;
              push_job.chars = {in_rx_byte, date_r[4:0], time_r};
            end
          end
          cif_nxt = cif_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      fld_r     <= '0;
      cif_r     <= '0;
      lat_r     <= 1'b0;
    end else begin
      in_sent_r <= in_sent_nxt;
      fld_r     <= fld_nxt;
      cif_r     <= cif_nxt;
      lat_r     <= lat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (time_wr) begin
      time_r[cif_r[2:0]] <= in_rx_byte;
    end
    if (date_wr) begin
      date_r[cif_r[2:0]] <= in_rx_byte;
    end
  end

endmodule

// ===== design/nrmc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_queue
// Two-entry job queue between parser and result sequencer.
// ----------------------------------------------------------------------------
module nrmc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nrmc_pkg::job_t     push_job,
  input  logic               pop,
  output logic               full,
  output logic               avail,
  output nrmc_pkg::job_t     head
);
  import nrmc_pkg::*;

  job_t       ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== design/nrmc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_back
// Result sequencer: unrolls queued jobs into result transfers through an
// output register.
// ----------------------------------------------------------------------------
module nrmc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               avail,
  input  nrmc_pkg::job_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_char_value,
  output logic               out_last
);
  import nrmc_pkg::*;

  logic       valid_r;
  logic [2:0] kind_r;
  logic [7:0] char_r;
  logic       last_r;
  logic [3:0] idx_r, idx_nxt;
  logic       load;
  logic       done;

  assign load = avail && (!valid_r || !out_stall);
  assign done = !head.burst || (idx_r == BURST_LAST);
  assign pop  = load && done;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = done ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.kind;
      char_r <= head.burst ? head.chars[idx_r] : head.chars[0];
      last_r <= done;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_char_value = char_r;
  assign out_last       = last_r;

endmodule

// ===== design/nmea_rmc_field_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_field_extractor
// Picks latitude, longitude, time and date out of RMC sentences.
// Path: a byte's first result goes through the job queue and then the output
//   register of the sequencer before it can transfer.
// Throughput: one byte per cycle; a time/date burst holds the sequencer
//   to its end, and input stalls once the two-entry job queue is full.
// Reset: synchronous active-low; parser leaves any sentence, queue empties,
//   no-lock digit returns to ASCII '8'.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor #(
  parameter logic [7:0] NO_LOCK_RESET = 8'd56
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_char_value,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_no_lock_year_digit
);
  import nrmc_pkg::*;

  logic [7:0] no_lock_r;
  logic       q_full;
  logic       q_avail;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_lock_r <= NO_LOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      no_lock_r <= cfg_no_lock_year_digit;
    end
  end

  nrmc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_rx_byte    (in_rx_byte),
    .q_full        (q_full),
    .no_lock_digit (no_lock_r),
    .push          (push),
    .push_job      (push_job)
  );

  nrmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .avail    (q_avail),
    .head     (head)
  );

  nrmc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .avail          (q_avail),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_char_value (out_char_value),
    .out_last       (out_last)
  );

  // status results carry no character and end their burst
  a_status_fmt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NOGPS || out_kind == KIND_NOTIME)
    |-> out_char_value == 8'd0 && out_last)
    else $error("status result malformed");

  // only time/date bursts span several transfers
  a_multi_only_time : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == KIND_TIME)
    else $error("non-final result outside a time/date burst");

  // nothing is queued when the queue is full
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full queue");

endmodule
